/* rtl/snwa_pkg.sv */
// ----------------------------------------------------------------------------
// snwa_pkg
// types and constants shared by the windowed snr / noise average
// ----------------------------------------------------------------------------
package snwa_pkg;

  localparam int DATA_W = 8;
  localparam int MEAN_W = 15;
  localparam int Q_W    = 8;

  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

  typedef struct packed {
    logic [DATA_W-1:0] snr_sample;
    logic [DATA_W-1:0] noise_sample;
  } snwa_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] snr_now;
    logic [DATA_W-1:0] noise_now;
    logic [MEAN_W-1:0] snr_mean_scaled;
    logic [MEAN_W-1:0] noise_mean_scaled;
  } snwa_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } snwa_ctl_t;

endpackage

/* rtl/snwa_sum.sv */
// ----------------------------------------------------------------------------
// snwa_sum
// sample ring with one read port and a running sum that adds a byte per cycle while step is set
// ----------------------------------------------------------------------------
module snwa_sum
  import snwa_pkg::*;
#(
  parameter int WINDOW = 8,
  parameter int PW     = 3,
  parameter int SW     = 12
) (
  input  logic              clk,
  input  logic              wr,
  input  logic [PW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd,
  input  logic [PW-1:0]     rd_addr,
  input  snwa_ctl_t         ctl,
  output logic [SW-1:0]     sum
);

  logic [DATA_W-1:0] mem [WINDOW];
  logic [DATA_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum <= '0;
    end else if (ctl.step) begin
      sum <= sum + SW'(rdata);
    end
  end

endmodule

/* rtl/snwa_div.sv */
// ----------------------------------------------------------------------------
// snwa_div
// restoring divider, one quotient bit per cycle while step is set
// ----------------------------------------------------------------------------
module snwa_div
  import snwa_pkg::*;
#(
  parameter int SW = 12,
  parameter int CW = 4
) (
  input  logic           clk,
  input  snwa_ctl_t      ctl,
  input  logic [SW-1:0]  dividend,
  input  logic [CW-1:0]  divisor,
  output logic [Q_W-1:0] quotient
);

  logic [CW-1:0] rem;
  logic [SW-1:0] dq;
  logic [CW:0]   trial;
  logic          ge;
  logic [CW:0]   diff;

  assign trial    = {rem, dq[SW-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign quotient = dq[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      dq  <= dividend;
    end else if (ctl.step) begin
      rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
      dq  <= {dq[SW-2:0], ge};
    end
  end

endmodule

/* rtl/snwa_mul.sv */
// ----------------------------------------------------------------------------
// snwa_mul
// shift-add multiply of the mean by the scale factor, with saturation
// ----------------------------------------------------------------------------
module snwa_mul
  import snwa_pkg::*;
#(
  parameter int SCALE = 100
) (
  input  logic              clk,
  input  snwa_ctl_t         ctl,
  input  logic [Q_W-1:0]    mean,
  output logic [MEAN_W-1:0] scaled
);

  localparam int SCW    = $clog2(SCALE + 1);
  localparam int PROD_W = (Q_W + SCW > MEAN_W + 1) ? Q_W + SCW : MEAN_W + 1;

  logic [Q_W-1:0]    q;
  logic [PROD_W-1:0] mc;
  logic [PROD_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q   <= mean;
      mc  <= PROD_W'(SCALE);
      acc <= '0;
    end else if (ctl.step) begin
      if (q[0]) begin
        acc <= acc + mc;
      end
      mc <= {mc[PROD_W-2:0], 1'b0};
      q  <= {1'b0, q[Q_W-1:1]};
    end
  end

  assign scaled = (acc > PROD_W'(MEAN_MAX)) ? MEAN_MAX : acc[MEAN_W-1:0];

endmodule

/* rtl/snr_noise_window_average.sv */
// ----------------------------------------------------------------------------
// snr_noise_window_average
// moving average of snr and noise floor over a ring of WINDOW frames
// ----------------------------------------------------------------------------
// operation: after an input beat is taken, sum the valid entries (count, up to
//   WINDOW), divide each SW-bit sum by count, SW = 8 + clog2(WINDOW + 1), and
//   scale the Q_W = 8 bit mean by SCALE, then load out_data once it is free
// throughput: a new beat is taken only in idle, after the previous result is loaded
// reset: state, write position, count and out_valid cleared, ring contents undefined until written
module snr_noise_window_average
  import snwa_pkg::*;
#(
  parameter int WINDOW = 8,
  parameter int SCALE  = 100
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  snwa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output snwa_out_t out_data
);

  localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = DATA_W + CW;
  localparam int KW0 = $clog2(SW + 1);
  localparam int KW  = (CW > KW0) ? CW : KW0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]        state;
  logic [KW-1:0]     cnt;
  logic [PW-1:0]     wpos;
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] snr_hold;
  logic [DATA_W-1:0] noise_hold;

  logic              accept;
  logic              rd;
  logic              out_free;
  snwa_ctl_t         sum_ctl;
  snwa_ctl_t         div_ctl;
  snwa_ctl_t         mul_ctl;
  logic [SW-1:0]     snr_sum;
  logic [SW-1:0]     noise_sum;
  logic [Q_W-1:0]    snr_q;
  logic [Q_W-1:0]    noise_q;
  logic [MEAN_W-1:0] snr_scaled;
  logic [MEAN_W-1:0] noise_scaled;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign rd           = (state == S_SUM) && (cnt < KW'(count));
  assign sum_ctl.load = accept;
  assign sum_ctl.step = (state == S_SUM) && (cnt != '0);
  assign div_ctl.load = (state == S_DIV) && (cnt == '0);
  assign div_ctl.step = (state == S_DIV) && (cnt != '0);
  assign mul_ctl.load = (state == S_MUL) && (cnt == '0);
  assign mul_ctl.step = (state == S_MUL) && (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wpos      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count != CW'(WINDOW)) begin
              count <= count + 1'b1;
            end
            wpos  <= (wpos == PW'(WINDOW - 1)) ? '0 : wpos + 1'b1;
            cnt   <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt == KW'(count)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt == KW'(SW)) begin
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MUL: begin
          if (cnt == KW'(Q_W)) begin
            cnt   <= '0;
            state <= S_LOAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snr_hold   <= in_data.snr_sample;
      noise_hold <= in_data.noise_sample;
    end
    if ((state == S_LOAD) && out_free) begin
      out_data.snr_now           <= snr_hold;
      out_data.noise_now         <= noise_hold;
      out_data.snr_mean_scaled   <= snr_scaled;
      out_data.noise_mean_scaled <= noise_scaled;
    end
  end

  // snr lane
  snwa_sum #(.WINDOW(WINDOW), .PW(PW), .SW(SW)) u_snr_sum (
    .clk     (clk),
    .wr      (accept),
    .wr_addr (wpos),
    .wr_data (in_data.snr_sample),
    .rd      (rd),
    .rd_addr (cnt[PW-1:0]),
    .ctl     (sum_ctl),
    .sum     (snr_sum)
  );

  snwa_div #(.SW(SW), .CW(CW)) u_snr_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (snr_sum),
    .divisor  (count),
    .quotient (snr_q)
  );

  snwa_mul #(.SCALE(SCALE)) u_snr_mul (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mean   (snr_q),
    .scaled (snr_scaled)
  );

  // noise lane
  snwa_sum #(.WINDOW(WINDOW), .PW(PW), .SW(SW)) u_noise_sum (
    .clk     (clk),
    .wr      (accept),
    .wr_addr (wpos),
    .wr_data (in_data.noise_sample),
    .rd      (rd),
    .rd_addr (cnt[PW-1:0]),
    .ctl     (sum_ctl),
    .sum     (noise_sum)
  );

  snwa_div #(.SW(SW), .CW(CW)) u_noise_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (noise_sum),
    .divisor  (count),
    .quotient (noise_q)
  );

  snwa_mul #(.SCALE(SCALE)) u_noise_mul (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mean   (noise_q),
    .scaled (noise_scaled)
  );

endmodule
